// ===== src/oic_pkg.sv =====
// Shared types, constants and lookup functions for the order-preserving integer compressor.
// Used by oic_div, order_preserving_int_compress_core and tb_top; depends on nothing.
package oic_pkg;

    localparam int VALUE_W = 64;
    localparam int SIZE_W  = 7;
    localparam int DIVS_W  = 7;

    localparam logic [SIZE_W-1:0] SIZE_MAX = 7'd64;

    localparam logic [1:0] CLASS_TOP  = 2'h3;
    localparam logic [1:0] CLASS_HIGH = 2'h2;
    localparam logic [1:0] CLASS_MID  = 2'h1;
    localparam logic [1:0] CLASS_LOW  = 2'h0;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [SIZE_W-1:0]  in_size;
        logic [SIZE_W-1:0]  out_size;
    } oic_in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] code;
        logic               bad_request;
    } oic_out_t;

    typedef struct packed {
        logic              found;
        logic [SIZE_W-1:0] t0;
        logic [SIZE_W-1:0] t1;
        logic [SIZE_W-1:0] t2;
    } oic_thr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_DONE
    } oic_state_t;

    function automatic oic_thr_t size_lookup(input logic [SIZE_W-1:0] size);
        oic_thr_t r;
        r = '{found: 1'b1, t0: '0, t1: '0, t2: '0};
        case (size)
            7'd64:   begin r.t0 = 7'd32; r.t1 = 7'd48; r.t2 = 7'd56; end
            7'd56:   begin r.t0 = 7'd24; r.t1 = 7'd32; r.t2 = 7'd48; end
            7'd48:   begin r.t0 = 7'd24; r.t1 = 7'd32; r.t2 = 7'd40; end
            7'd40:   begin r.t0 = 7'd16; r.t1 = 7'd24; r.t2 = 7'd32; end
            7'd32:   begin r.t0 = 7'd12; r.t1 = 7'd16; r.t2 = 7'd24; end
            7'd24:   begin r.t0 = 7'd10; r.t1 = 7'd12; r.t2 = 7'd16; end
            7'd16:   begin r.t0 = 7'd7;  r.t1 = 7'd9;  r.t2 = 7'd10; end
            7'd12:   begin r.t0 = 7'd8;  r.t1 = 7'd10; r.t2 = 7'd11; end
            7'd11:   begin r.t0 = 7'd8;  r.t1 = 7'd9;  r.t2 = 7'd10; end
            7'd10:   begin r.t0 = 7'd7;  r.t1 = 7'd8;  r.t2 = 7'd9;  end
            7'd9:    begin r.t0 = 7'd5;  r.t1 = 7'd6;  r.t2 = 7'd7;  end
            7'd8:    begin r.t0 = 7'd4;  r.t1 = 7'd5;  r.t2 = 7'd6;  end
            7'd7:    begin r.t0 = 7'd4;  r.t1 = 7'd5;  r.t2 = 7'd6;  end
            7'd6:    begin r.t0 = 7'd2;  r.t1 = 7'd3;  r.t2 = 7'd4;  end
            7'd5:    begin r.t0 = 7'd2;  r.t1 = 7'd3;  r.t2 = 7'd4;  end
            7'd4:    begin r.t0 = 7'd1;  r.t1 = 7'd2;  r.t2 = 7'd2;  end
            7'd3:    begin r.t0 = 7'd0;  r.t1 = 7'd1;  r.t2 = 7'd2;  end
            7'd2:    begin r.t0 = 7'd0;  r.t1 = 7'd1;  r.t2 = 7'd2;  end
            7'd1:    begin r.t0 = 7'd0;  r.t1 = 7'd1;  r.t2 = 7'd1;  end
            default: r.found = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic at_least_pow2(input logic [VALUE_W-1:0] v,
                                           input logic [SIZE_W-1:0]  t);
        return (v >> t) != '0;
    endfunction

endpackage

// ===== src/oic_div.sv =====
// Radix-2 restoring divider: 64-bit dividend by a 7-bit divisor, one quotient bit a cycle.
// Depends on oic_pkg.
module oic_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [oic_pkg::VALUE_W-1:0]  dividend,
    input  logic [oic_pkg::DIVS_W-1:0]   divisor,
    output logic                         done,
    output logic [oic_pkg::VALUE_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(oic_pkg::VALUE_W);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [oic_pkg::DIVS_W-1:0]  rem_reg, rem_next;
    logic [oic_pkg::DIVS_W-1:0]  dvs_reg, dvs_next;
    logic [oic_pkg::VALUE_W-1:0] quo_reg, quo_next;
    logic [oic_pkg::DIVS_W:0]    trial;
    logic                        qbit;

    always_comb begin
        trial = {rem_reg, quo_reg[oic_pkg::VALUE_W-1]};
        qbit  = trial >= {1'b0, dvs_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(oic_pkg::VALUE_W - 1);
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = qbit ? oic_pkg::DIVS_W'(trial - {1'b0, dvs_reg})
                            : trial[oic_pkg::DIVS_W-1:0];
            quo_next = {quo_reg[oic_pkg::VALUE_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/order_preserving_int_compress_core.sv =====
// Order-preserving integer compressor top level: sequencer, level datapath, output register.
// Depends on oic_pkg and oic_div.
// Sequence: a rejected or single-level request passes through EVAL and DONE; each extra level adds
// an evaluate state and a pass through the shared radix-2 divider in the DIV state.
// Throughput: one request at a time; the next is taken once the result is in the output register.
// Reset: synchronous, active low; clears the sequencer, the divider control and the output valid.
module order_preserving_int_compress_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  oic_pkg::oic_in_t s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output oic_pkg::oic_out_t m_payload
);

    oic_pkg::oic_state_t state_reg, state_next;

    logic [oic_pkg::VALUE_W-1:0] v_reg, v_next;
    logic [oic_pkg::SIZE_W-1:0]  isz_reg, isz_next;
    logic [oic_pkg::SIZE_W-1:0]  osz_reg, osz_next;
    logic [oic_pkg::VALUE_W-1:0] acc_reg, acc_next;
    logic                        bad_reg, bad_next;
    logic                        first_reg, first_next;
    logic                        m_valid_reg, m_valid_next;
    oic_pkg::oic_out_t           m_data_reg, m_data_next;

    oic_pkg::oic_thr_t           thr;
    logic [1:0]                  cls;
    logic [oic_pkg::SIZE_W-1:0]  nsz;
    logic [oic_pkg::SIZE_W-1:0]  osz_m2;
    logic [oic_pkg::VALUE_W-1:0] cls_shift;
    logic                        req_err;
    logic                        eval_done;
    logic                        out_free;
    logic                        div_start;
    logic                        div_done;
    logic [oic_pkg::DIVS_W-1:0]  div_divisor;
    logic [oic_pkg::VALUE_W-1:0] div_quotient;

    always_comb begin
        thr = oic_pkg::size_lookup(isz_reg);
        if (oic_pkg::at_least_pow2(v_reg, thr.t2)) begin
            cls = oic_pkg::CLASS_TOP;
            nsz = isz_reg;
        end else if (oic_pkg::at_least_pow2(v_reg, thr.t1)) begin
            cls = oic_pkg::CLASS_HIGH;
            nsz = thr.t2;
        end else if (oic_pkg::at_least_pow2(v_reg, thr.t0)) begin
            cls = oic_pkg::CLASS_MID;
            nsz = thr.t1;
        end else begin
            cls = oic_pkg::CLASS_LOW;
            nsz = thr.t0;
        end
        osz_m2      = osz_reg - 7'd2;
        cls_shift   = {{(oic_pkg::VALUE_W-2){1'b0}}, cls} << osz_m2[5:0];
        div_divisor = isz_reg - osz_m2;
        req_err     = !thr.found || (osz_reg > isz_reg) ||
                      ((isz_reg < oic_pkg::SIZE_MAX) && ((v_reg >> isz_reg) != '0));
        eval_done   = (first_reg && req_err) || !thr.found || (osz_reg == 7'd0) ||
                      (osz_reg == 7'd1) || (osz_m2 >= nsz);
        out_free    = !m_valid_reg || m_ready;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            oic_pkg::ST_IDLE: if (s_valid) state_next = oic_pkg::ST_EVAL;
            oic_pkg::ST_EVAL: state_next = eval_done ? oic_pkg::ST_DONE : oic_pkg::ST_DIV;
            oic_pkg::ST_DIV:  if (div_done) state_next = oic_pkg::ST_EVAL;
            oic_pkg::ST_DONE: if (out_free) state_next = oic_pkg::ST_IDLE;
            default:          state_next = oic_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        v_next       = v_reg;
        isz_next     = isz_reg;
        osz_next     = osz_reg;
        acc_next     = acc_reg;
        bad_next     = bad_reg;
        first_next   = first_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        div_start    = 1'b0;
        case (state_reg)
            oic_pkg::ST_IDLE: begin
                if (s_valid) begin
                    v_next     = s_payload.value;
                    isz_next   = s_payload.in_size;
                    osz_next   = s_payload.out_size;
                    acc_next   = '0;
                    bad_next   = 1'b0;
                    first_next = 1'b1;
                end
            end
            oic_pkg::ST_EVAL: begin
                first_next = 1'b0;
                if (first_reg && req_err) begin
                    acc_next = '0;
                    bad_next = 1'b1;
                end else if (!thr.found || osz_reg == 7'd0) begin
                    acc_next = acc_reg;
                end else if (osz_reg == 7'd1) begin
                    acc_next = acc_reg | {{(oic_pkg::VALUE_W-1){1'b0}}, cls[1]};
                end else if (osz_m2 >= nsz) begin
                    acc_next = acc_reg | cls_shift | v_reg;
                end else begin
                    acc_next  = acc_reg | cls_shift;
                    isz_next  = nsz;
                    osz_next  = osz_m2;
                    div_start = 1'b1;
                end
            end
            oic_pkg::ST_DIV: begin
                if (div_done) begin
                    v_next = div_quotient;
                end
            end
            oic_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{code: acc_reg, bad_request: bad_reg};
                end
            end
            default: begin
                first_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= oic_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            first_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            first_reg   <= first_next;
        end
        v_reg      <= v_next;
        isz_reg    <= isz_next;
        osz_reg    <= osz_next;
        acc_reg    <= acc_next;
        bad_reg    <= bad_next;
        m_data_reg <= m_data_next;
    end

    oic_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (v_reg),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign s_ready   = state_reg == oic_pkg::ST_IDLE;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.bad_request |-> m_data_reg.code == '0)
        else $error("rejected request carries a nonzero code");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == oic_pkg::ST_DIV)
        else $error("divider finished outside the divide state");

    a_level_sizes: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == oic_pkg::ST_DIV |-> osz_reg < isz_reg)
        else $error("deeper level has out size not below in size");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in flight");

    a_div_start_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> state_reg == oic_pkg::ST_DIV)
        else $error("divider started without entering the divide state");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for order_preserving_int_compress_core: directed, random and output back-pressure
// requests, each result checked against a behavioral compressor. Depends on oic_pkg and the core.
module tb_top;

    localparam int CYCLE_LIMIT     = 4_000_000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int RANDOM_REQUESTS = 255;
    localparam int QUIET_REQUESTS  = 40;
    localparam int HOLD_OFF_CYCLES = 400;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    oic_pkg::oic_in_t  s_payload;
    logic              m_valid;
    logic              m_ready;
    oic_pkg::oic_out_t m_payload;

    oic_pkg::oic_out_t pending_codes[$];
    int       mismatch_count = 0;
    int       cycles = 0;
    int       hold_off_len = 0;
    bit       quiet = 1'b0;
    int       known_sizes[19] = '{64, 56, 48, 40, 32, 24, 16, 12, 11, 10,
                                  9, 8, 7, 6, 5, 4, 3, 2, 1};

    order_preserving_int_compress_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb_top failed");
        $finish;
    end

    function automatic bit size_thresholds(input logic [oic_pkg::SIZE_W-1:0] size,
                                           output logic [oic_pkg::SIZE_W-1:0] t0,
                                           output logic [oic_pkg::SIZE_W-1:0] t1,
                                           output logic [oic_pkg::SIZE_W-1:0] t2);
        logic [3*oic_pkg::SIZE_W-1:0] t;
        bit                           ok;
        ok = 1'b1;
        case (size)
            7'd64:   t = {7'd32, 7'd48, 7'd56};
            7'd56:   t = {7'd24, 7'd32, 7'd48};
            7'd48:   t = {7'd24, 7'd32, 7'd40};
            7'd40:   t = {7'd16, 7'd24, 7'd32};
            7'd32:   t = {7'd12, 7'd16, 7'd24};
            7'd24:   t = {7'd10, 7'd12, 7'd16};
            7'd16:   t = {7'd7,  7'd9,  7'd10};
            7'd12:   t = {7'd8,  7'd10, 7'd11};
            7'd11:   t = {7'd8,  7'd9,  7'd10};
            7'd10:   t = {7'd7,  7'd8,  7'd9};
            7'd9:    t = {7'd5,  7'd6,  7'd7};
            7'd8:    t = {7'd4,  7'd5,  7'd6};
            7'd7:    t = {7'd4,  7'd5,  7'd6};
            7'd6:    t = {7'd2,  7'd3,  7'd4};
            7'd5:    t = {7'd2,  7'd3,  7'd4};
            7'd4:    t = {7'd1,  7'd2,  7'd2};
            7'd3:    t = {7'd0,  7'd1,  7'd2};
            7'd2:    t = {7'd0,  7'd1,  7'd2};
            7'd1:    t = {7'd0,  7'd1,  7'd1};
            default: begin
                t  = '0;
                ok = 1'b0;
            end
        endcase
        {t0, t1, t2} = t;
        return ok;
    endfunction

    function automatic oic_pkg::oic_out_t compress_value(input oic_pkg::oic_in_t req);
        oic_pkg::oic_out_t          res;
        logic [63:0]                v;
        logic [63:0]                acc;
        logic [oic_pkg::SIZE_W-1:0] isz;
        logic [oic_pkg::SIZE_W-1:0] osz;
        logic [oic_pkg::SIZE_W-1:0] nsz;
        logic [oic_pkg::SIZE_W-1:0] t0;
        logic [oic_pkg::SIZE_W-1:0] t1;
        logic [oic_pkg::SIZE_W-1:0] t2;
        logic [oic_pkg::SIZE_W-1:0] divisor;
        logic [1:0]                 cls;
        bit                         found;
        bit                         done;
        res   = '0;
        v     = req.value;
        isz   = req.in_size;
        osz   = req.out_size;
        found = size_thresholds(isz, t0, t1, t2);
        if (!found || osz > isz ||
            (isz < oic_pkg::SIZE_MAX && (v >> isz) != 64'd0)) begin
            res.bad_request = 1'b1;
            return res;
        end
        acc  = '0;
        done = 1'b0;
        while (!done) begin
            found = size_thresholds(isz, t0, t1, t2);
            if (v >= (64'd1 << t2)) begin
                cls = oic_pkg::CLASS_TOP;
                nsz = isz;
            end else if (v >= (64'd1 << t1)) begin
                cls = oic_pkg::CLASS_HIGH;
                nsz = t2;
            end else if (v >= (64'd1 << t0)) begin
                cls = oic_pkg::CLASS_MID;
                nsz = t1;
            end else begin
                cls = oic_pkg::CLASS_LOW;
                nsz = t0;
            end
            if (osz == 7'd0) begin
                done = 1'b1;
            end else if (osz == 7'd1) begin
                acc  = acc | {63'd0, cls[1]};
                done = 1'b1;
            end else begin
                acc = acc | ({62'd0, cls} << (osz - 7'd2));
                if (osz - 7'd2 >= nsz) begin
                    acc  = acc | v;
                    done = 1'b1;
                end else begin
                    divisor = isz - osz + 7'd2;
                    v       = v / {57'd0, divisor};
                    isz     = nsz;
                    osz     = osz - 7'd2;
                end
            end
        end
        res.code = acc;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 60);
    endfunction

    function automatic int pick_size();
        if ($urandom_range(0, 3) == 0) begin
            return known_sizes[$urandom_range(0, 18)];
        end
        return known_sizes[$urandom_range(6, 18)];
    endfunction

    function automatic logic [63:0] value_below(input int width);
        logic [63:0] r;
        int          len;
        r = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) begin
            r = 64'd1 << $urandom_range(0, width - 1);
            return ($urandom_range(0, 1) == 1) ? r : r - 64'd1;
        end
        len = $urandom_range(0, width);
        if (len == 0) begin
            return 64'd0;
        end
        return r >> (64 - len);
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_result(input oic_pkg::oic_out_t want, input oic_pkg::oic_out_t got);
        if (got.code !== want.code) begin
            flag_mismatch($sformatf("code got %h want %h", got.code, want.code));
        end
        if (got.bad_request !== want.bad_request) begin
            flag_mismatch($sformatf("bad_request got %b want %b",
                                    got.bad_request, want.bad_request));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_codes.size() == 0) begin
                flag_mismatch($sformatf("unexpected result code %h bad_request %b",
                                        m_payload.code, m_payload.bad_request));
            end else begin
                check_result(pending_codes.pop_front(), m_payload);
            end
        end
    end

    initial begin
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_len > 0) begin
                m_ready <= 1'b0;
                repeat (hold_off_len) @(negedge aclk);
                hold_off_len = 0;
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    task automatic send_request(input oic_pkg::oic_in_t req);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_codes.push_back(compress_value(req));
    endtask

    task automatic send_fields(input logic [63:0] value,
                               input logic [oic_pkg::SIZE_W-1:0] in_size,
                               input logic [oic_pkg::SIZE_W-1:0] out_size);
        oic_pkg::oic_in_t req;
        req.value    = value;
        req.in_size  = in_size;
        req.out_size = out_size;
        send_request(req);
    endtask

    task automatic test_boundaries();
        send_fields(64'd0, 7'd1, 7'd0);
        send_fields(64'd1, 7'd1, 7'd1);
        send_fields(64'd0, 7'd64, 7'd64);
        send_fields('1, 7'd64, 7'd64);
        send_fields('1, 7'd64, 7'd1);
        send_fields('1, 7'd64, 7'd0);
        send_fields(64'd255, 7'd8, 7'd8);
        send_fields(64'd1 << 40, 7'd64, 7'd20);
        send_fields(64'h7fff_ffff, 7'd32, 7'd2);
        send_fields(64'd5, 7'd3, 7'd3);
        send_fields(64'd1000, 7'd16, 7'd9);
        send_fields(64'd1 << 47, 7'd48, 7'd48);
    endtask

    task automatic test_rejects();
        send_fields(64'd0, 7'd0, 7'd0);
        send_fields(64'd5, 7'd13, 7'd4);
        send_fields('1, 7'd127, 7'd127);
        send_fields(64'd0, 7'd65, 7'd2);
        send_fields(64'd3, 7'd8, 7'd9);
        send_fields(64'd0, 7'd56, 7'd64);
        send_fields(64'd1, 7'd1, 7'd127);
        send_fields(64'd256, 7'd8, 7'd4);
        send_fields(64'h1_0000_0000, 7'd32, 7'd32);
        send_fields(64'd2, 7'd1, 7'd0);
    endtask

    task automatic test_random_traffic();
        oic_pkg::oic_in_t req;
        int               sel;
        int               sz;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            quiet = (n < QUIET_REQUESTS);
            sel   = $urandom_range(0, 99);
            if (sel < 85) begin
                sz           = pick_size();
                req.in_size  = oic_pkg::SIZE_W'(sz);
                req.out_size = oic_pkg::SIZE_W'(($urandom_range(0, 4) == 0) ?
                               $urandom_range(0, sz) :
                               $urandom_range(0, (sz < 12) ? sz : 12));
                req.value    = value_below(sz);
            end else if (sel < 92) begin
                sz           = known_sizes[$urandom_range(1, 18)];
                req.in_size  = oic_pkg::SIZE_W'(sz);
                req.out_size = oic_pkg::SIZE_W'($urandom_range(0, sz));
                req.value    = {$urandom, $urandom} | (64'd1 << $urandom_range(sz, 63));
            end else begin
                req.value    = {$urandom, $urandom};
                req.in_size  = oic_pkg::SIZE_W'($urandom_range(0, 127));
                req.out_size = oic_pkg::SIZE_W'($urandom_range(0, 127));
            end
            send_request(req);
        end
        quiet = 1'b0;
    endtask

    task automatic test_output_backpressure();
        oic_pkg::oic_in_t req;
        hold_off_len = HOLD_OFF_CYCLES;
        for (int n = 0; n < 8; n++) begin
            req.in_size  = 7'd8;
            req.out_size = oic_pkg::SIZE_W'($urandom_range(0, 8));
            req.value    = value_below(8);
            send_request(req);
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_payload = '0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        test_boundaries();
        test_rejects();
        test_output_backpressure();
        test_random_traffic();
        test_output_backpressure();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_codes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
